// File: rtl/core/partition_allocator_fit_policies_core_assert.svh
// Assertion macros for the partition allocator core.
`ifndef PARTITION_ALLOCATOR_FIT_POLICIES_CORE_ASSERT_SVH
`define PARTITION_ALLOCATOR_FIT_POLICIES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PA_ASSERT(label, clk, rst_n, prop, msg)
`define PA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/pafp_pkg.sv
// Package: types, constants and codes for the partition allocator.
`timescale 1ns / 1ps
package pafp_pkg;
    localparam int MaxParts = 16;
    localparam int IdxW = $clog2(MaxParts);
    localparam int CntW = $clog2(MaxParts + 1);
    localparam logic [15:0] MinSplitReset = 16'd10;
    localparam logic [15:0] TotalSizeReset = 16'd1024;

    localparam logic [1:0] CfgPolicy = 2'd0;
    localparam logic [1:0] CfgMinSplit = 2'd1;
    localparam logic [1:0] CfgTotalSize = 2'd2;

    localparam logic [1:0] PolBest = 2'd1;
    localparam logic [1:0] PolWorst = 2'd2;

    localparam logic [2:0] StOk = 3'd0;
    localparam logic [2:0] StNoFit = 3'd1;
    localparam logic [2:0] StBadSize = 3'd2;
    localparam logic [2:0] StBadIndex = 3'd3;
    localparam logic [2:0] StFull = 3'd4;

    // one table entry
    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        busy;
    } t_entry;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_INSERT,   // shift right from pos, then write pos and pos+1
        OP_REMOVE,   // shift left from pos, entry pos-1 gets the merged size
        OP_MARK      // set busy of entry pos to a value
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IdxW-1:0] pos;
        logic [15:0]     req;
        logic [15:0]     left;
        logic [15:0]     msize;
        logic            busy;
        logic [15:0]     init_size;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FREE1,
        S_FREE2,
        S_DONE
    } t_state;
endpackage

// File: rtl/core/pafp_cell.sv
// One table cell: holds an entry and takes its left or right neighbour on shifts.
`timescale 1ns / 1ps
module pafp_cell
    import pafp_pkg::*;
#(
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IdxW-1:0] i_my_idx,
    input  logic            i_is_first,
    input  t_cmd            i_cmd,
    input  t_entry          i_left,
    input  t_entry          i_right,
    output t_entry          o_entry
);
    t_entry r_entry, n_entry;

    // pick the next entry from the broadcast command
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            OP_INIT: begin
                n_entry.start = '0;
                n_entry.busy = 1'b0;
                n_entry.size = i_is_first ? i_cmd.init_size : '0;
            end
            OP_INSERT: begin
                if (i_my_idx == i_cmd.pos) begin
                    n_entry.size = i_cmd.req;
                    n_entry.busy = 1'b1;
                end else if (i_my_idx == i_cmd.pos + 1'b1 && i_cmd.pos != '1) begin
                    n_entry.start = i_left.start + i_cmd.req;
                    n_entry.size = i_cmd.left;
                    n_entry.busy = 1'b0;
                end else if (i_my_idx > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            OP_REMOVE: begin
                if (i_my_idx + 1'b1 == i_cmd.pos && i_cmd.pos != '0)
                    n_entry.size = i_cmd.msize;
                else if (i_my_idx >= i_cmd.pos && i_my_idx != '1)
                    n_entry = i_right;
            end
            OP_MARK: begin
                if (i_my_idx == i_cmd.pos)
                    n_entry.busy = i_cmd.busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.busy <= 1'b0;
        end else begin
            r_entry.busy <= n_entry.busy;
        end
        r_entry.start <= n_entry.start;
        r_entry.size <= n_entry.size;
    end

    assign o_entry = r_entry;
endmodule

// File: rtl/core/partition_allocator_fit_policies_core.sv
// Top level: request sequencer over a chain of partition table cells.
// An allocate scans the table, one entry a cycle, then takes a decide and a
// done step; a free takes two free steps and a done step, a zero-size
// allocate goes straight to done, and a bad index ends after the first free
// step. A new item is taken only after the result strobe of the last one.
// Synchronous active-low reset restores the state, count and configuration
// registers and one free partition of 1024; no item is taken while that
// initial load is pending. The receiver cannot stall.
`timescale 1ns / 1ps
`include "partition_allocator_fit_policies_core_assert.svh"
module partition_allocator_fit_policies_core
    import pafp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_req_type,
    input  logic [15:0] i_alloc_size,
    input  logic [3:0]  i_partition_index,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_alloc_address,
    output logic [15:0] o_granted_size,
    output logic [3:0]  o_alloc_index
);
    logic [1:0]  r_policy;
    logic [15:0] r_min_split;
    logic        r_init, r_type;
    logic [15:0] r_req;
    logic [IdxW-1:0] r_pidx, r_scan, r_pick, n_scan, n_pick;
    logic [CntW-1:0] r_count, n_count;
    logic        r_found, n_found;
    t_state      r_state, n_state;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_addr, n_addr, r_grant, n_grant;
    logic [3:0]  r_aidx, n_aidx;
    logic        r_valid, n_valid;
    t_cmd        cmd;
    t_entry      ent [MaxParts];
    t_entry      lft [MaxParts];
    t_entry      rgt [MaxParts];
    t_entry      cur, pk, nb;
    logic [15:0] left_sz;
    logic        better;

    // chain of cells
    for (genvar g = 0; g < MaxParts; g++) begin : g_cell
        assign lft[g] = (g == 0) ? ent[0] : ent[(g == 0) ? 0 : g - 1];
        assign rgt[g] = (g == MaxParts - 1) ? ent[g] : ent[(g == MaxParts - 1) ? g : g + 1];
        pafp_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_my_idx(IdxW'(g)),
            .i_is_first(g == 0), .i_cmd(cmd), .i_left(lft[g]), .i_right(rgt[g]),
            .o_entry(ent[g])
        );
    end

    assign cur = ent[r_scan];
    assign pk = ent[r_pick];
    assign nb = ent[r_pidx];
    assign left_sz = pk.size - r_req;

    // policy compare for the scan step
    always_comb begin
        case (r_policy)
            PolBest:  better = cur.size < pk.size;
            PolWorst: better = cur.size > pk.size;
            default:  better = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start && !busy) begin
                if (i_req_type) n_state = S_FREE1;
                else if (i_alloc_size == '0) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN: if (CntW'(r_scan) + 1'b1 >= r_count) n_state = S_DECIDE;
            S_DECIDE: n_state = S_DONE;
            S_FREE1: n_state = (CntW'(r_pidx) >= r_count) ? S_DONE : S_FREE2;
            S_FREE2: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and commands
    always_comb begin
        cmd = '0;
        cmd.op = OP_HOLD;
        cmd.init_size = i_cfg_data;
        n_scan = r_scan; n_pick = r_pick; n_found = r_found; n_count = r_count;
        n_status = r_status; n_addr = r_addr; n_grant = r_grant; n_aidx = r_aidx;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_scan = '0; n_pick = '0; n_found = 1'b0;
                n_status = StOk; n_addr = '0; n_grant = '0; n_aidx = '0;
                if (start && !busy && !i_req_type && i_alloc_size == '0)
                    n_status = StBadSize;
            end
            S_SCAN: begin
                if (!cur.busy && cur.size >= r_req && (!r_found || better)) begin
                    n_pick = r_scan; n_found = 1'b1;
                end
                n_scan = r_scan + 1'b1;
            end
            S_DECIDE: begin
                if (!r_found) n_status = StNoFit;
                else if (left_sz <= r_min_split) begin
                    cmd.op = OP_MARK; cmd.pos = r_pick; cmd.busy = 1'b1;
                    n_addr = pk.start; n_grant = pk.size; n_aidx = 4'(r_pick);
                end else if (r_count >= CntW'(MaxParts)) n_status = StFull;
                else begin
                    cmd.op = OP_INSERT; cmd.pos = r_pick; cmd.req = r_req;
                    cmd.left = left_sz; n_count = r_count + 1'b1;
                    n_addr = pk.start; n_grant = r_req; n_aidx = 4'(r_pick);
                end
            end
            S_FREE1: begin
                if (CntW'(r_pidx) >= r_count) n_status = StBadIndex;
                else if (r_pidx != '0 && !ent[r_pidx - 1'b1].busy) begin
                    // merge into left neighbour
                    cmd.op = OP_REMOVE; cmd.pos = r_pidx;
                    cmd.msize = ent[r_pidx - 1'b1].size + nb.size;
                    n_count = r_count - 1'b1;
                    n_pick = r_pidx - 1'b1;
                end else begin
                    cmd.op = OP_MARK; cmd.pos = r_pidx; cmd.busy = 1'b0;
                    n_pick = r_pidx;
                end
            end
            S_FREE2: begin
                if (CntW'(r_pick) + 1'b1 < r_count && !ent[r_pick + 1'b1].busy) begin
                    cmd.op = OP_REMOVE; cmd.pos = r_pick + 1'b1;
                    cmd.msize = pk.size + ent[r_pick + 1'b1].size;
                    n_count = r_count - 1'b1;
                end
            end
            S_DONE: n_valid = 1'b1;
            default: ;
        endcase
        if (r_init || (i_cfg_we && i_cfg_index == CfgTotalSize)) begin
            cmd.op = OP_INIT;
            cmd.init_size = r_init ? TotalSizeReset : i_cfg_data;
            n_count = CntW'(1);
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_policy <= '0; r_min_split <= MinSplitReset;
            r_init <= 1'b1; r_count <= CntW'(1);
            r_valid <= 1'b0; r_found <= 1'b0;
        end else begin
            r_init <= 1'b0;
            r_state <= n_state; r_count <= n_count; r_valid <= n_valid;
            r_found <= n_found;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgPolicy:    r_policy <= i_cfg_data[1:0];
                    CfgMinSplit:  r_min_split <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_scan <= n_scan; r_pick <= n_pick; r_status <= n_status;
        r_addr <= n_addr; r_grant <= n_grant; r_aidx <= n_aidx;
        if (start && !busy) begin
            r_type <= i_req_type; r_req <= i_alloc_size; r_pidx <= i_partition_index;
        end
    end

    assign busy = (r_state != S_IDLE) || r_init || r_valid;
    assign o_valid = r_valid;
    assign o_status = r_valid ? r_status : '0;
    assign o_alloc_address = (r_valid && !r_type) ? r_addr : '0;
    assign o_granted_size = (r_valid && !r_type) ? r_grant : '0;
    assign o_alloc_index = (r_valid && !r_type) ? r_aidx : '0;

    `PA_ASSERT(a_count_range, i_clk, i_rst_n, (r_count >= CntW'(1) && r_count <= CntW'(MaxParts)), "partition count out of range")
    `PA_ASSERT(a_valid_one, i_clk, i_rst_n, r_valid |=> !r_valid, "result strobe longer than one cycle")
    `PA_ASSERT(a_done_valid, i_clk, i_rst_n, (r_state == S_DONE) |=> r_valid, "done without result")
endmodule
